>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same, on the project clock and reset names.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

>>> hw/rtl/nmp_pkg.sv
// ----------------------------------------------------------------------------
// nmp_pkg
// Types and fixed constants of the normal map perturb pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package nmp_pkg;
   localparam int TEXEL_BITS = 8;
   localparam int COMP_BITS  = 16;
   localparam int WEIGHT_BITS = 10;
   localparam int PROD_BITS  = 26;
   localparam int P_BITS     = 26;
   localparam int PSQ_BITS   = 50;
   localparam int LEN2_BITS  = 52;
   localparam int MAG_BITS   = 16;
   localparam int WEIGHT_BIAS = 255;

   typedef logic [2:0][COMP_BITS-1:0] vec_type;
   typedef logic [2:0][P_BITS-1:0]    pvec_type;
   typedef logic [2:0][PSQ_BITS-1:0]  psq_type;

   typedef struct packed {
      logic       valid;
      logic       degen;
      logic [2:0] neg;
   } ctl_type;
endpackage
`default_nettype wire

>>> hw/rtl/nmp_front.sv
// ----------------------------------------------------------------------------
// nmp_front
// Texel decode, basis products, per-axis sums, squares and squared length.
// Four register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module nmp_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 valid_in,
   input  logic [2:0][nmp_pkg::TEXEL_BITS-1:0]  texel_in,
   input  nmp_pkg::vec_type                     tangent_in,
   input  nmp_pkg::vec_type                     bitangent_in,
   input  nmp_pkg::vec_type                     normal_in,
   output logic                                 valid_out,
   output nmp_pkg::pvec_type                    p_out,
   output nmp_pkg::psq_type                     psq_out,
   output logic [nmp_pkg::LEN2_BITS-1:0]        len2_out
);
   import nmp_pkg::*;

   logic [3:0] valid_ff;
   logic [2:0][2:0][PROD_BITS-1:0] prod_ff, prod_in;
   pvec_type p1_ff, p1_in, p2_ff, p3_ff;
   psq_type  psq_ff, psq_in, psq3_ff;
   logic [LEN2_BITS-1:0] len2_ff, len2_in;
   logic signed [WEIGHT_BITS-1:0] wgt [3];
   logic signed [2*P_BITS-1:0] sq;
   logic [LEN2_BITS-1:0] lsum;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         wgt[c] = $signed({1'b0, texel_in[c], 1'b0})
                  - $signed(WEIGHT_BITS'(WEIGHT_BIAS));
      end
      for (int ax = 0; ax < 3; ax++) begin
         prod_in[ax][0] = PROD_BITS'($signed(tangent_in[ax]) * wgt[0]);
         prod_in[ax][1] = PROD_BITS'($signed(bitangent_in[ax]) * wgt[1]);
         prod_in[ax][2] = PROD_BITS'($signed(normal_in[ax]) * wgt[2]);
      end
      for (int ax = 0; ax < 3; ax++) begin
         p1_in[ax] = P_BITS'($signed(prod_ff[ax][0]) + $signed(prod_ff[ax][1])
                             + $signed(prod_ff[ax][2]));
      end
      for (int ax = 0; ax < 3; ax++) begin
         sq = $signed(p1_ff[ax]) * $signed(p1_ff[ax]);
         psq_in[ax] = sq[PSQ_BITS-1:0];
      end
      lsum = LEN2_BITS'(psq_ff[0]) + LEN2_BITS'(psq_ff[1]) + LEN2_BITS'(psq_ff[2]);
      len2_in = lsum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], valid_in};
      end
      prod_ff <= prod_in;
      p1_ff   <= p1_in;
      p2_ff   <= p1_ff;
      psq_ff  <= psq_in;
      p3_ff   <= p2_ff;
      psq3_ff <= psq_ff;
      len2_ff <= len2_in;
   end

   assign valid_out = valid_ff[3];
   assign p_out     = p3_ff;
   assign psq_out   = psq3_ff;
   assign len2_out  = len2_ff;
endmodule
`default_nettype wire

>>> hw/rtl/nmp_bit_step.sv
// ----------------------------------------------------------------------------
// nmp_bit_step
// One magnitude bit of the rounded normalization, all three axes.
// Keeps S = k^2*L and T = k*L with k = 2m-1, updated by shifts and adds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module nmp_bit_step #(
   parameter int W  = 89,
   parameter int MB = 16,
   parameter int J  = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  nmp_pkg::ctl_type      ctl_in,
   input  logic [W-1:0]          len2_in,
   input  logic [2:0][W-1:0]     s_in,
   input  logic [2:0][W-1:0]     t_in,
   input  logic [2:0][W-1:0]     r_in,
   input  logic [2:0][MB-1:0]    m_in,
   output nmp_pkg::ctl_type      ctl_out,
   output logic [W-1:0]          len2_out,
   output logic [2:0][W-1:0]     s_out,
   output logic [2:0][W-1:0]     t_out,
   output logic [2:0][W-1:0]     r_out,
   output logic [2:0][MB-1:0]    m_out
);
   import nmp_pkg::*;

   ctl_type ctl_ff;
   logic [W-1:0] len2_ff;
   logic [2:0][W-1:0] s_ff, s_in2, t_ff, t_in2, r_ff;
   logic [2:0][MB-1:0] m_ff, m_in2;
   logic [W-1:0] s_cand;
   logic ok;

   always_comb begin
      for (int ax = 0; ax < 3; ax++) begin
         s_cand = W'($signed(s_in[ax]) + ($signed(t_in[ax]) <<< (J + 2))
                     + $signed(len2_in << (2 * J + 2)));
         ok = ((J == MB - 1) || !m_in[ax][MB-1])
              && ($signed(s_cand) <= $signed(r_in[ax]));
         s_in2[ax] = ok ? s_cand : s_in[ax];
         t_in2[ax] = ok ? W'(t_in[ax] + (len2_in << (J + 1))) : t_in[ax];
         m_in2[ax] = ok ? (m_in[ax] | (MB'(1) << J)) : m_in[ax];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.degen <= ctl_in.degen;
      ctl_ff.neg   <= ctl_in.neg;
      len2_ff <= len2_in;
      s_ff <= s_in2;
      t_ff <= t_in2;
      r_ff <= r_in;
      m_ff <= m_in2;
   end

   assign ctl_out  = ctl_ff;
   assign len2_out = len2_ff;
   assign s_out    = s_ff;
   assign t_out    = t_ff;
   assign r_out    = r_ff;
   assign m_out    = m_ff;
endmodule
`default_nettype wire

>>> hw/rtl/normal_map_perturb_core.sv
// ----------------------------------------------------------------------------
// normal_map_perturb_core
// Tangent-space normal mapping: decodes a texel, blends the basis vectors
// and returns the unit-length perturbed normal in signed fixed point.
//
// Usage:
//  - Request: drive the texel bytes and the tangent, bitangent and normal
//    words on req_* and raise start; the word is taken at every clock edge
//    where start is high and busy is low. busy stays low, so a new word
//    can be given on every cycle.
//  - Response: rsp_valid is high for one cycle with the result word on
//    rsp_bumped_* and rsp_degenerate. The receiver cannot stall; every
//    result appears exactly once.
//  - The pipeline has four front stages (decode/products, sums,
//    squares, length), one stage per magnitude bit (16 bits, three axes in
//    parallel), and the output register. Throughput is one word a cycle.
//  - A zero-length sum gives a zero vector with rsp_degenerate set.
//  - Synchronous reset drops all words in flight; nothing else is kept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module normal_map_perturb_core #(
   parameter int FRAC_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_texel_red,
   input  logic [7:0]  req_texel_green,
   input  logic [7:0]  req_texel_blue,
   input  logic signed [15:0] req_tangent_x,
   input  logic signed [15:0] req_tangent_y,
   input  logic signed [15:0] req_tangent_z,
   input  logic signed [15:0] req_bitangent_x,
   input  logic signed [15:0] req_bitangent_y,
   input  logic signed [15:0] req_bitangent_z,
   input  logic signed [15:0] req_surface_normal_x,
   input  logic signed [15:0] req_surface_normal_y,
   input  logic signed [15:0] req_surface_normal_z,
   output logic        rsp_valid,
   output logic signed [15:0] rsp_bumped_x,
   output logic signed [15:0] rsp_bumped_y,
   output logic signed [15:0] rsp_bumped_z,
   output logic        rsp_degenerate
);
   import nmp_pkg::*;

   localparam int RSH = 2 * FRAC_BITS + 2;
   localparam int W   = ((RSH + PSQ_BITS + 2 > 88) ? RSH + PSQ_BITS + 2 : 88) + 1;
   localparam int LAT = 4 + MAG_BITS + 1;

   logic f_valid;
   pvec_type f_p;
   psq_type  f_psq;
   logic [LEN2_BITS-1:0] f_len2;

   ctl_type ch_ctl [MAG_BITS+1];
   logic [W-1:0] ch_len2 [MAG_BITS+1];
   logic [2:0][W-1:0] ch_s [MAG_BITS+1];
   logic [2:0][W-1:0] ch_t [MAG_BITS+1];
   logic [2:0][W-1:0] ch_r [MAG_BITS+1];
   logic [2:0][MAG_BITS-1:0] ch_m [MAG_BITS+1];

   logic valid_ff, degen_ff;
   logic [2:0][COMP_BITS-1:0] bump_ff, bump_in;
   ctl_type last;

   assign busy = 1'b0;

   nmp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .valid_in     (start & ~busy),
      .texel_in     ({req_texel_blue, req_texel_green, req_texel_red}),
      .tangent_in   ({req_tangent_z, req_tangent_y, req_tangent_x}),
      .bitangent_in ({req_bitangent_z, req_bitangent_y, req_bitangent_x}),
      .normal_in    ({req_surface_normal_z, req_surface_normal_y,
                      req_surface_normal_x}),
      .valid_out    (f_valid),
      .p_out        (f_p),
      .psq_out      (f_psq),
      .len2_out     (f_len2)
   );

   always_comb begin
      ch_ctl[0].valid = f_valid;
      ch_ctl[0].degen = (f_len2 == '0);
      ch_len2[0] = W'(f_len2);
      for (int ax = 0; ax < 3; ax++) begin
         ch_ctl[0].neg[ax] = f_p[ax][P_BITS-1];
         ch_s[0][ax] = W'(f_len2);
         ch_t[0][ax] = W'(-W'(f_len2));
         ch_r[0][ax] = W'(f_psq[ax]) << RSH;
         ch_m[0][ax] = '0;
      end
   end

   for (genvar i = 0; i < MAG_BITS; i++) begin : g_step
      nmp_bit_step #(.W(W), .MB(MAG_BITS), .J(MAG_BITS - 1 - i)) u_step (
         .clock    (clock),
         .reset    (reset),
         .ctl_in   (ch_ctl[i]),
         .len2_in  (ch_len2[i]),
         .s_in     (ch_s[i]),
         .t_in     (ch_t[i]),
         .r_in     (ch_r[i]),
         .m_in     (ch_m[i]),
         .ctl_out  (ch_ctl[i+1]),
         .len2_out (ch_len2[i+1]),
         .s_out    (ch_s[i+1]),
         .t_out    (ch_t[i+1]),
         .r_out    (ch_r[i+1]),
         .m_out    (ch_m[i+1])
      );
   end

   assign last = ch_ctl[MAG_BITS];

   always_comb begin
      for (int ax = 0; ax < 3; ax++) begin
         if (last.degen) begin
            bump_in[ax] = '0;
         end else if (last.neg[ax]) begin
            bump_in[ax] = -ch_m[MAG_BITS][ax];
         end else if (ch_m[MAG_BITS][ax][MAG_BITS-1]) begin
            bump_in[ax] = {1'b0, {(COMP_BITS-1){1'b1}}};
         end else begin
            bump_in[ax] = ch_m[MAG_BITS][ax];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= last.valid;
      end
      degen_ff <= last.degen;
      bump_ff  <= bump_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_degenerate = degen_ff;
   assign rsp_bumped_x   = bump_ff[0];
   assign rsp_bumped_y   = bump_ff[1];
   assign rsp_bumped_z   = bump_ff[2];

   `ASSERT_STD(a_rsp_follows_req, rsp_valid |-> $past(start, LAT), "response without request")
   `ASSERT_STD(a_degen_zero, (rsp_valid && rsp_degenerate) |-> (bump_ff == '0), "degen not zero")
   `ASSERT_STD(a_unit_nonzero, (rsp_valid && !rsp_degenerate) |-> (bump_ff != '0), "zero result")
endmodule
`default_nettype wire
